// ===== hdl/drt_pkg.sv =====
`default_nettype none

package drt_pkg;

  // Store geometry and coordinate width.
  localparam int MAX_RECTS   = 64;
  localparam int COORD_WIDTH = 12;
  localparam int IDX_W       = $clog2(MAX_RECTS);
  localparam int CNT_W       = $clog2(MAX_RECTS + 1);

  // Incoming rectangle fields are 16-bit signed; clipping needs two guard bits.
  localparam int IN_WIDTH    = 16;
  localparam int CLIP_W      = IN_WIDTH + 2;

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Command codes.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_DAMAGE     = 2'd0;
  localparam cmd_t CMD_DAMAGE_ALL = 2'd1;
  localparam cmd_t CMD_PRESENT    = 2'd2;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] w;
    logic [COORD_WIDTH-1:0] h;
  } box_t;

  localparam int BOX_W = 4 * COORD_WIDTH;

  // Clipped rectangle, with keep low when nothing is left on screen.
  typedef struct packed {
    logic keep;
    box_t box;
  } clip_t;

  // Result of testing a stored entry against the new rectangle.
  typedef struct packed {
    logic touch;
    box_t merged;
  } merge_t;

endpackage

`default_nettype wire

// ===== hdl/drt_ram.sv =====
`default_nettype none

module drt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/drt_clip.sv =====
`default_nettype none

module drt_clip (
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_x,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_y,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_w,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_h,
  input  wire logic        [drt_pkg::COORD_WIDTH-1:0] screen_w,
  input  wire logic        [drt_pkg::COORD_WIDTH-1:0] screen_h,
  output drt_pkg::clip_t                              clip
);

  typedef struct packed {
    logic                            keep;
    logic [drt_pkg::COORD_WIDTH-1:0] pos;
    logic [drt_pkg::COORD_WIDTH-1:0] len;
  } axis_t;

  // One axis: pull a negative start back to zero, cut the end at the screen
  // edge, and keep the span only if some length remains.
  function automatic axis_t clip_axis(
    input logic signed [drt_pkg::IN_WIDTH-1:0]    p,
    input logic signed [drt_pkg::IN_WIDTH-1:0]    n,
    input logic        [drt_pkg::COORD_WIDTH-1:0] lim
  );
    logic signed [drt_pkg::CLIP_W-1:0] p_ext;
    logic signed [drt_pkg::CLIP_W-1:0] p1;
    logic signed [drt_pkg::CLIP_W-1:0] n1;
    logic signed [drt_pkg::CLIP_W-1:0] lim_s;
    logic signed [drt_pkg::CLIP_W-1:0] span_end;
    logic signed [drt_pkg::CLIP_W-1:0] n2;
    axis_t r;
    p_ext    = {{(drt_pkg::CLIP_W - drt_pkg::IN_WIDTH){p[drt_pkg::IN_WIDTH-1]}}, p};
    p1       = p[drt_pkg::IN_WIDTH-1] ? '0 : p_ext;
    n1       = {{(drt_pkg::CLIP_W - drt_pkg::IN_WIDTH){n[drt_pkg::IN_WIDTH-1]}}, n}
               + (p[drt_pkg::IN_WIDTH-1] ? p_ext : '0);
    lim_s    = {{(drt_pkg::CLIP_W - drt_pkg::COORD_WIDTH){1'b0}}, lim};
    span_end = p1 + n1;
    n2       = (span_end > lim_s) ? (lim_s - p1) : n1;
    r.keep   = !n2[drt_pkg::CLIP_W-1] && (n2 != '0);
    r.pos    = p1[drt_pkg::COORD_WIDTH-1:0];
    r.len    = n2[drt_pkg::COORD_WIDTH-1:0];
    return r;
  endfunction

  axis_t ax;
  axis_t ay;

  always_comb begin
    ax         = clip_axis(rect_x, rect_w, screen_w);
    ay         = clip_axis(rect_y, rect_h, screen_h);
    clip.keep  = ax.keep && ay.keep;
    clip.box.x = ax.pos;
    clip.box.w = ax.len;
    clip.box.y = ay.pos;
    clip.box.h = ay.len;
  end

endmodule

`default_nettype wire

// ===== hdl/drt_merge.sv =====
`default_nettype none

module drt_merge (
  input  wire drt_pkg::box_t stored,
  input  wire drt_pkg::box_t fresh,
  output drt_pkg::merge_t    result
);

  localparam int EW = drt_pkg::COORD_WIDTH + 1;

  logic [EW-1:0] a_l, a_r, a_t, a_b;
  logic [EW-1:0] b_l, b_r, b_t, b_b;
  logic [EW-1:0] u_l, u_r, u_t, u_b;
  logic [EW-1:0] u_w, u_h;

  // Edges are compared inclusively, so boxes that only share an edge merge.
  always_comb begin
    a_l = {1'b0, stored.x};
    a_t = {1'b0, stored.y};
    a_r = a_l + {1'b0, stored.w};
    a_b = a_t + {1'b0, stored.h};
    b_l = {1'b0, fresh.x};
    b_t = {1'b0, fresh.y};
    b_r = b_l + {1'b0, fresh.w};
    b_b = b_t + {1'b0, fresh.h};

    result.touch = !((b_l > a_r) || (b_r < a_l) || (b_t > a_b) || (b_b < a_t));

    u_l = (a_l < b_l) ? a_l : b_l;
    u_t = (a_t < b_t) ? a_t : b_t;
    u_r = (a_r > b_r) ? a_r : b_r;
    u_b = (a_b > b_b) ? a_b : b_b;
    u_w = u_r - u_l;
    u_h = u_b - u_t;

    result.merged.x = u_l[drt_pkg::COORD_WIDTH-1:0];
    result.merged.y = u_t[drt_pkg::COORD_WIDTH-1:0];
    result.merged.w = u_w[drt_pkg::COORD_WIDTH-1:0];
    result.merged.h = u_h[drt_pkg::COORD_WIDTH-1:0];
  end

endmodule

`default_nettype wire

// ===== hdl/dirty_rectangle_tracker_top.sv =====
`default_nettype none

// Damage tracker for screen repaint.
// Commands arrive as items on the input channel (in_valid / in_ready) and
// repaint regions leave as items on the output channel (out_valid /
// out_ready). A damage item clips its rectangle to the screen and merges it
// into the first stored entry that it overlaps or abuts, or appends it; when
// the store of MAX_RECTS entries is full the whole-screen flag is set instead.
// A damage-all item sets the flag and empties the store. A present item sends
// one whole-screen region when the flag is set, otherwise every stored entry
// in order with last on the final one, and then clears flag and store.
// The store sits in a single synchronous RAM and a damage item scans it one
// entry a cycle, holding the block until the scan ends; an early entry that
// takes the merge ends it sooner. Damage-all is done on acceptance. A present
// of stored regions first primes the RAM read in ST_PRES_RD, a whole-screen
// present goes straight to ST_PRES_ALL, and regions then leave one a cycle
// while out_ready is high; the RAM read port sets that pace.
// The output register lets the next item be accepted while the final region
// still waits. A stalled receiver simply holds the present walk in place.
// Reset empties the store, sets the whole-screen flag and loads a 1024 by 768
// screen; the screen size registers are written through the cfg port, and the
// user must do so only while the block is idle; the block itself does not enforce it.
module dirty_rectangle_tracker_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [drt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [drt_pkg::COORD_WIDTH-1:0] cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic        [1:0]                      command,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_x,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_y,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_w,
  input  wire logic signed [drt_pkg::IN_WIDTH-1:0]    rect_h,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [drt_pkg::COORD_WIDTH-1:0] out_x,
  output logic             [drt_pkg::COORD_WIDTH-1:0] out_y,
  output logic             [drt_pkg::COORD_WIDTH-1:0] out_w,
  output logic             [drt_pkg::COORD_WIDTH-1:0] out_h,
  output logic                                        whole_screen,
  output logic                                        last
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_PRES_RD  = 3'd3;
  localparam logic [2:0] ST_PRES     = 3'd4;
  localparam logic [2:0] ST_PRES_ALL = 3'd5;

  localparam logic [drt_pkg::CNT_W-1:0] COUNT_FULL = drt_pkg::CNT_W'(drt_pkg::MAX_RECTS);

  logic [2:0]                      state;
  logic [drt_pkg::IDX_W-1:0]       idx;
  logic [drt_pkg::CNT_W-1:0]       count;
  logic                            full_flag;
  logic [drt_pkg::COORD_WIDTH-1:0] screen_w;
  logic [drt_pkg::COORD_WIDTH-1:0] screen_h;
  drt_pkg::clip_t                  fresh;

  drt_pkg::clip_t                  clip;
  drt_pkg::merge_t                 merge;
  drt_pkg::box_t                   rd_box;
  logic [drt_pkg::BOX_W-1:0]       rd_data;

  logic                            in_accept;
  logic                            out_load;
  logic                            advance;
  logic                            idx_last;
  logic [drt_pkg::IDX_W-1:0]       idx_inc;
  logic [drt_pkg::IDX_W-1:0]       rd_addr;
  logic                            ram_we;
  logic [drt_pkg::IDX_W-1:0]       wr_addr;
  drt_pkg::box_t                   wr_box;
  logic                            out_fill;
  drt_pkg::box_t                   out_box_next;
  logic                            whole_next;
  logic                            last_next;

  drt_clip u_clip (
    .rect_x   (rect_x),
    .rect_y   (rect_y),
    .rect_w   (rect_w),
    .rect_h   (rect_h),
    .screen_w (screen_w),
    .screen_h (screen_h),
    .clip     (clip)
  );

  assign rd_box = drt_pkg::box_t'(rd_data);

  drt_merge u_merge (
    .stored (rd_box),
    .fresh  (fresh.box),
    .result (merge)
  );

  drt_ram #(
    .WIDTH (drt_pkg::BOX_W),
    .DEPTH (drt_pkg::MAX_RECTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_box),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = !out_valid || out_ready;
  assign idx_inc   = idx + 1'b1;
  assign idx_last  = ((drt_pkg::CNT_W'(idx) + drt_pkg::CNT_W'(1)) == count);

  // The read port runs one entry ahead whenever the current entry is used up,
  // so a scan or an unstalled present walk moves one entry per cycle. While
  // the present walk is stalled the same entry is read again and holds.
  assign advance = (state == ST_SCAN) || ((state == ST_PRES) && out_load);
  assign rd_addr = advance ? idx_inc : idx;

  // Store writes: merge back into the touching entry, or append at the end.
  always_comb begin
    ram_we  = 1'b0;
    wr_addr = idx;
    wr_box  = fresh.box;
    if ((state == ST_START) && fresh.keep && (count == '0)) begin
      ram_we  = 1'b1;
      wr_addr = count[drt_pkg::IDX_W-1:0];
    end else if (state == ST_SCAN) begin
      if (merge.touch) begin
        ram_we = 1'b1;
        wr_box = merge.merged;
      end else if (idx_last && (count != COUNT_FULL)) begin
        ram_we  = 1'b1;
        wr_addr = count[drt_pkg::IDX_W-1:0];
      end
    end
  end

  // Output register loading.
  always_comb begin
    out_fill     = 1'b0;
    out_box_next = rd_box;
    whole_next   = 1'b0;
    last_next    = idx_last;
    if ((state == ST_PRES) && out_load) begin
      out_fill = 1'b1;
    end else if ((state == ST_PRES_ALL) && out_load) begin
      out_fill       = 1'b1;
      out_box_next.x = '0;
      out_box_next.y = '0;
      out_box_next.w = screen_w;
      out_box_next.h = screen_h;
      whole_next     = 1'b1;
      last_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      count     <= '0;
      full_flag <= 1'b1;
      screen_w  <= drt_pkg::COORD_WIDTH'(1024);
      screen_h  <= drt_pkg::COORD_WIDTH'(768);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          drt_pkg::REG_SCREEN_WIDTH: begin
            screen_w <= cfg_data;
          end
          drt_pkg::REG_SCREEN_HEIGHT: begin
            screen_h <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (out_fill) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            idx <= '0;
            case (command)
              drt_pkg::CMD_DAMAGE: begin
                if (!full_flag) begin
                  state <= ST_START;
                end
              end
              drt_pkg::CMD_DAMAGE_ALL: begin
                full_flag <= 1'b1;
                count     <= '0;
              end
              drt_pkg::CMD_PRESENT: begin
                if (full_flag) begin
                  state <= ST_PRES_ALL;
                end else if (count != '0) begin
                  state <= ST_PRES_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_START: begin
          if (!fresh.keep) begin
            state <= ST_IDLE;
          end else if (count == '0) begin
            count <= drt_pkg::CNT_W'(1);
            state <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (merge.touch) begin
            state <= ST_IDLE;
          end else if (idx_last) begin
            if (count != COUNT_FULL) begin
              count <= count + 1'b1;
            end else begin
              full_flag <= 1'b1;
            end
            state <= ST_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        ST_PRES_RD: begin
          state <= ST_PRES;
        end
        ST_PRES: begin
          if (out_load) begin
            if (idx_last) begin
              count <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        ST_PRES_ALL: begin
          if (out_load) begin
            full_flag <= 1'b0;
            count     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: the clipped rectangle and the output region.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fresh <= clip;
    end
    if (out_fill) begin
      out_x        <= out_box_next.x;
      out_y        <= out_box_next.y;
      out_w        <= out_box_next.w;
      out_h        <= out_box_next.h;
      whole_screen <= whole_next;
      last         <= last_next;
    end
  end

`ifndef SYNTHESIS
  // The entry count never runs past the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("entry count beyond store depth");

  // Store writes land on a live entry or on the next free one.
  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (drt_pkg::CNT_W'(wr_addr) <= count) && (count != COUNT_FULL || merge.touch))
    else $error("store write outside the live entries");

  // A damage-all item leaves the flag set and the store empty.
  a_damage_all: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (command == drt_pkg::CMD_DAMAGE_ALL)) |=> (full_flag && (count == '0)))
    else $error("damage-all did not mark the whole screen");

  // A whole-screen region is always the only, and so the last, region.
  a_whole_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && whole_screen) |-> last)
    else $error("whole-screen region without last");
`endif

endmodule

`default_nettype wire

// ===== verif/dirty_rectangle_tracker_top_tb.sv =====
`timescale 1ns / 100ps

// One repaint region as it leaves the block.
typedef struct packed {
  logic [drt_pkg::COORD_WIDTH-1:0] x;
  logic [drt_pkg::COORD_WIDTH-1:0] y;
  logic [drt_pkg::COORD_WIDTH-1:0] w;
  logic [drt_pkg::COORD_WIDTH-1:0] h;
  logic                            whole;
  logic                            is_last;
} region_t;

// Keeps its own copy of the damage list and predicts the repaint regions.
class repaint_scoreboard;
  drt_pkg::box_t                   damage_list[drt_pkg::MAX_RECTS];
  int                              entries;
  bit                              whole_flag;
  logic [drt_pkg::COORD_WIDTH-1:0] screen_w;
  logic [drt_pkg::COORD_WIDTH-1:0] screen_h;
  region_t                         expected_regions[$];
  int                              mismatches;

  function new();
    entries    = 0;
    whole_flag = 1'b1;
    screen_w   = 12'd1024;
    screen_h   = 12'd768;
    mismatches = 0;
  endfunction

  function void set_screen(logic [drt_pkg::COORD_WIDTH-1:0] w,
                           logic [drt_pkg::COORD_WIDTH-1:0] h);
    screen_w = w;
    screen_h = h;
  endfunction

  function int pending();
    return expected_regions.size();
  endfunction

  // Clips the rectangle, then merges it into the first entry it touches or appends it.
  function void add_damage(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] w, logic signed [15:0] h);
    int cx, cy, cw, ch;
    int ex, ey, ew, eh;
    int l, t, r, d;
    if (whole_flag) return;
    cx = x;
    cy = y;
    cw = w;
    ch = h;
    if (cx < 0) begin
      cw = cw + cx;
      cx = 0;
    end
    if (cy < 0) begin
      ch = ch + cy;
      cy = 0;
    end
    if (cx + cw > int'(screen_w)) cw = int'(screen_w) - cx;
    if (cy + ch > int'(screen_h)) ch = int'(screen_h) - cy;
    if (cw <= 0 || ch <= 0) return;
    for (int i = 0; i < entries; i++) begin
      ex = damage_list[i].x;
      ey = damage_list[i].y;
      ew = damage_list[i].w;
      eh = damage_list[i].h;
      if (!(cx > ex + ew || cx + cw < ex || cy > ey + eh || cy + ch < ey)) begin
        l = (ex < cx) ? ex : cx;
        t = (ey < cy) ? ey : cy;
        r = (ex + ew > cx + cw) ? ex + ew : cx + cw;
        d = (ey + eh > cy + ch) ? ey + eh : cy + ch;
        r = r - l;
        d = d - t;
        damage_list[i].x = l[11:0];
        damage_list[i].y = t[11:0];
        damage_list[i].w = r[11:0];
        damage_list[i].h = d[11:0];
        return;
      end
    end
    if (entries < drt_pkg::MAX_RECTS) begin
      damage_list[entries].x = cx[11:0];
      damage_list[entries].y = cy[11:0];
      damage_list[entries].w = cw[11:0];
      damage_list[entries].h = ch[11:0];
      entries++;
    end else begin
      whole_flag = 1'b1;
    end
  endfunction

  function void note_command(drt_pkg::cmd_t cmd, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] w,
                             logic signed [15:0] h);
    region_t reg_out;
    case (cmd)
      drt_pkg::CMD_DAMAGE: begin
        add_damage(x, y, w, h);
      end
      drt_pkg::CMD_DAMAGE_ALL: begin
        whole_flag = 1'b1;
        entries    = 0;
      end
      drt_pkg::CMD_PRESENT: begin
        if (whole_flag) begin
          reg_out.x       = '0;
          reg_out.y       = '0;
          reg_out.w       = screen_w;
          reg_out.h       = screen_h;
          reg_out.whole   = 1'b1;
          reg_out.is_last = 1'b1;
          expected_regions.push_back(reg_out);
        end else begin
          for (int i = 0; i < entries; i++) begin
            reg_out.x       = damage_list[i].x;
            reg_out.y       = damage_list[i].y;
            reg_out.w       = damage_list[i].w;
            reg_out.h       = damage_list[i].h;
            reg_out.whole   = 1'b0;
            reg_out.is_last = (i + 1 == entries);
            expected_regions.push_back(reg_out);
          end
        end
        whole_flag = 1'b0;
        entries    = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function void check_region(region_t got);
    region_t want;
    if (expected_regions.size() == 0) begin
      $error("region with nothing expected: x=%0d y=%0d w=%0d h=%0d",
             got.x, got.y, got.w, got.h);
      mismatches++;
      return;
    end
    want = expected_regions.pop_front();
    if (got.x !== want.x) begin
      $error("out_x: expected %0d, got %0d", want.x, got.x);
      mismatches++;
    end
    if (got.y !== want.y) begin
      $error("out_y: expected %0d, got %0d", want.y, got.y);
      mismatches++;
    end
    if (got.w !== want.w) begin
      $error("out_w: expected %0d, got %0d", want.w, got.w);
      mismatches++;
    end
    if (got.h !== want.h) begin
      $error("out_h: expected %0d, got %0d", want.h, got.h);
      mismatches++;
    end
    if (got.whole !== want.whole) begin
      $error("whole_screen: expected %0d, got %0d", want.whole, got.whole);
      mismatches++;
    end
    if (got.is_last !== want.is_last) begin
      $error("last: expected %0d, got %0d", want.is_last, got.is_last);
      mismatches++;
    end
  endfunction
endclass

module dirty_rectangle_tracker_top_tb;

  // Command code that the block does not define; it must be swallowed silently.
  localparam drt_pkg::cmd_t CMD_UNUSED = 2'd3;

  // A damage item may still be scanning the store after the last region has
  // left, so the block is given the full scan time plus some margin before
  // any register write and before the final verdict.
  localparam int SETTLE_CYCLES = drt_pkg::MAX_RECTS + 16;

  // The long receiver hold-off, and the watchdog limit on cycles in which no
  // item moves on either channel. The limit is several times the longest
  // legitimate quiet stretch (hold-off, a calm spell and a full store scan).
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                                   clk       = 1'b0;
  logic                                   rst       = 1'b1;
  logic                                   cfg_wr_en = 1'b0;
  logic        [drt_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic        [drt_pkg::COORD_WIDTH-1:0] cfg_data  = '0;
  logic                                   in_valid  = 1'b0;
  logic                                   in_ready;
  logic        [1:0]                      command   = '0;
  logic signed [drt_pkg::IN_WIDTH-1:0]    rect_x    = '0;
  logic signed [drt_pkg::IN_WIDTH-1:0]    rect_y    = '0;
  logic signed [drt_pkg::IN_WIDTH-1:0]    rect_w    = '0;
  logic signed [drt_pkg::IN_WIDTH-1:0]    rect_h    = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic        [drt_pkg::COORD_WIDTH-1:0] out_x;
  logic        [drt_pkg::COORD_WIDTH-1:0] out_y;
  logic        [drt_pkg::COORD_WIDTH-1:0] out_w;
  logic        [drt_pkg::COORD_WIDTH-1:0] out_h;
  logic                                   whole_screen;
  logic                                   last;

  repaint_scoreboard sb = new();

  // Stimulus state shared by the driving tasks and the receiver process.
  int cur_w       = 1024;
  int cur_h       = 768;
  int prev_x      = 0;
  int prev_y      = 0;
  int prev_w      = 1;
  int prev_h      = 1;
  int items_sent  = 0;
  int tx_calm     = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit hold_req    = 1'b0;

  dirty_rectangle_tracker_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_w       (out_w),
    .out_h       (out_h),
    .whole_screen(whole_screen),
    .last        (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both channels are observed at the rising edge, where the block's outputs
  // still hold the values from before the edge. Regions are checked before
  // the accepted command is noted; a command's own regions can never leave
  // on the edge at which it is accepted, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_region('{x: out_x, y: out_y, w: out_w, h: out_h,
                          whole: whole_screen, is_last: last});
      end
      if (in_valid && in_ready) begin
        sb.note_command(drt_pkg::cmd_t'(command), rect_x, rect_y, rect_w, rect_h);
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver. Each pass of the loop makes exactly one assignment to
  // out_ready at one falling edge and may then hold it for further cycles.
  // It stalls in short random bursts, has calm spells with no stall at all,
  // and on request holds off for a long stretch so that the present walk
  // backs up and the block stops taking items.
  initial begin
    int r;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!rx_idle_on) begin
        out_ready <= 1'b1;
      end else if (r < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else if (r < 25) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns once it has been accepted. valid is left
  // high so that a following item can go out on the next falling edge
  // without valid dropping in between; a gap lowers it for whole cycles.
  task automatic send_item(input drt_pkg::cmd_t cmd, input int x, input int y,
                           input int w, input int h);
    int r;
    int gap;
    gap = 0;
    if (tx_idle_on) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) tx_calm = $urandom_range(10, 30);
        else if (r < 30) gap = $urandom_range(1, 7);
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    rect_x   <= 16'(x);
    rect_y   <= 16'(y);
    rect_w   <= 16'(w);
    rect_h   <= 16'(h);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Lowers valid and waits until every region has left and any damage scan
  // still running has surely finished.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_screen(input logic [drt_pkg::COORD_WIDTH-1:0] w,
                              input logic [drt_pkg::COORD_WIDTH-1:0] h);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= drt_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= drt_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_screen(w, h);
    cur_w = w;
    cur_h = h;
  endtask

  // One damage item: half the time a small rectangle on screen, else one
  // abutting the previous one, one hanging off the edges or a wholly random one.
  task automatic random_damage();
    int r;
    int x, y, w, h;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      x = $urandom_range(0, cur_w - 1);
      y = $urandom_range(0, cur_h - 1);
      w = $urandom_range(1, 48);
      h = $urandom_range(1, 48);
    end else if (r < 65) begin
      x = ($urandom_range(0, 1) == 1) ? prev_x + prev_w : prev_x;
      y = (x == prev_x) ? prev_y + prev_h : prev_y;
      w = $urandom_range(1, 32);
      h = $urandom_range(1, 32);
    end else if (r < 85) begin
      x = int'($urandom_range(0, 256)) - 128;
      y = int'($urandom_range(0, 256)) - 128;
      w = $urandom_range(1, cur_w + 128);
      h = $urandom_range(1, cur_h + 128);
    end else begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end
    prev_x = x;
    prev_y = y;
    prev_w = w;
    prev_h = h;
    send_item(drt_pkg::CMD_DAMAGE, x, y, w, h);
  endtask

  // A frame of drawing: some damage, now and then a damage-all, and usually
  // a present to close it. The ignored fields of the other commands carry
  // random content too.
  task automatic play_frame(input int n, input bit close);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(drt_pkg::CMD_DAMAGE_ALL, $urandom, $urandom, $urandom, $urandom);
      else
        random_damage();
    end
    if (close)
      send_item(drt_pkg::CMD_PRESENT, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic noise(input int n);
    for (int k = 0; k < n; k++)
      send_item(drt_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom,
                $urandom, $urandom);
  endtask

  // Fills the store with rectangles that can never touch: each sits inside
  // its own 16 by 16 cell with a margin, twelve cells to a row.
  task automatic fill_store(input int n);
    for (int k = 0; k < n; k++)
      send_item(drt_pkg::CMD_DAMAGE, (k % 12) * 16 + $urandom_range(1, 4),
                (k / 12) * 16 + $urandom_range(1, 4), $urandom_range(1, 8),
                $urandom_range(1, 8));
  endtask

  task automatic run_phase(input logic [drt_pkg::COORD_WIDTH-1:0] w,
                           input logic [drt_pkg::COORD_WIDTH-1:0] h,
                           input int budget, input int fill_count,
                           input bit hold);
    int start;
    int r;
    write_screen(w, h);
    start = items_sent;
    if (fill_count > 0) begin
      send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
      fill_store(fill_count);
      if (hold) hold_req = 1'b1;
      send_item(drt_pkg::CMD_PRESENT, $urandom, $urandom, $urandom, $urandom);
    end
    while (items_sent - start < budget + fill_count) begin
      r = $urandom_range(0, 99);
      if (r < 60) play_frame($urandom_range(1, 12), 1'b1);
      else if (r < 75) noise($urandom_range(1, 4));
      else if (r < 85) play_frame($urandom_range(1, 6), 1'b0);
      else play_frame($urandom_range(20, 40), 1'b1);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset screen of 1024 by 768. The flag is set out
    // of reset, so the first present gives the whole screen and the second
    // gives nothing; the unused command gives nothing either.
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    send_item(CMD_UNUSED, 5, 5, 5, 5);
    // A rectangle, one abutting it on the right, a separate one, one hanging
    // off the top-left corner that overlaps the first, one off the far corner.
    send_item(drt_pkg::CMD_DAMAGE, 10, 10, 10, 10);
    send_item(drt_pkg::CMD_DAMAGE, 20, 15, 5, 5);
    send_item(drt_pkg::CMD_DAMAGE, 100, 100, 4, 4);
    send_item(drt_pkg::CMD_DAMAGE, -5, -5, 20, 20);
    send_item(drt_pkg::CMD_DAMAGE, 1020, 760, 100, 100);
    // Field extremes, all of which clip away to nothing.
    send_item(drt_pkg::CMD_DAMAGE, -32768, -32768, 32767, 32767);
    send_item(drt_pkg::CMD_DAMAGE, 32767, 32767, 32767, 32767);
    send_item(drt_pkg::CMD_DAMAGE, 50, 50, 0, 5);
    send_item(drt_pkg::CMD_DAMAGE, 50, 50, -32768, -32768);
    // A full-width strip left after clipping a huge rectangle.
    send_item(drt_pkg::CMD_DAMAGE, -200, 300, 32767, 1);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    // Damage is ignored while the whole screen is marked.
    send_item(drt_pkg::CMD_DAMAGE_ALL, 0, 0, 0, 0);
    send_item(drt_pkg::CMD_DAMAGE, 5, 5, 5, 5);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    // A stored entry survives a screen shrink unclipped.
    send_item(drt_pkg::CMD_DAMAGE, 600, 600, 10, 10);
    write_screen(12'd100, 12'd50);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    send_item(drt_pkg::CMD_DAMAGE, 200, 10, 5, 5);
    // A zero screen drops all damage, and a whole-screen present reports
    // the zero size.
    write_screen(12'd0, 12'd0);
    send_item(drt_pkg::CMD_DAMAGE, 0, 0, 5, 5);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);
    send_item(drt_pkg::CMD_DAMAGE_ALL, 0, 0, 0, 0);
    send_item(drt_pkg::CMD_PRESENT, 0, 0, 0, 0);

    // Random part. The first phase overflows the store, the second fills it
    // exactly and holds the receiver off during the long present.
    run_phase(12'd1024, 12'd768, 6, $urandom_range(65, 70), 1'b0);
    run_phase(12'd4095, 12'd4095, 4, drt_pkg::MAX_RECTS, 1'b1);
    run_phase(12'd1, 12'd1, 4, 0, 1'b0);
    run_phase(12'd4095, 12'd1, 4, 0, 1'b0);
    // The closing stretch runs with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(12'($urandom_range(200, 2000)), 12'($urandom_range(200, 2000)),
              6, 0, 1'b0);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
